>>> src/dhcpos_pkg.sv
// shared types and constants of the dhcp option scanner
package dhcpos_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] region;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] option_code;
    logic [9:0] option_offset;
    logic [7:0] option_length;
    logic [2:0] status;
    logic [1:0] overload_value;
    logic       last_of_run;
  } out_beat_t;

  // results of one processed byte, in delivery order
  typedef struct packed {
    logic [1:0] cnt;
    out_beat_t  r0;
    out_beat_t  r1;
  } res_pair_t;

  localparam logic KIND_OPTION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_MAGIC     = 3'd1;
  localparam logic [2:0] ST_GARBLED_TYPE = 3'd2;
  localparam logic [2:0] ST_WRONG_TYPE   = 3'd3;
  localparam logic [2:0] ST_BAD_OVERLOAD = 3'd4;

  localparam logic [7:0] HKC_RESET = 8'd254;

endpackage

>>> src/dhcpos_parse.sv
// option walk state and per-byte parse logic
module dhcpos_parse #(
  parameter int MAX_REGION_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  dhcpos_pkg::in_beat_t beat,
  input  logic [7:0]           max_code,
  output dhcpos_pkg::res_pair_t res
);
  import dhcpos_pkg::*;

  localparam int POS_W = $clog2(MAX_REGION_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_REGION_BYTES);

  localparam logic [7:0] CODE_PAD      = 8'd0;
  localparam logic [7:0] CODE_END      = 8'd255;
  localparam logic [7:0] CODE_TYPE     = 8'd53;
  localparam logic [7:0] CODE_OVERLOAD = 8'd52;
  localparam logic [7:0] TYPE_LOW      = 8'd1;
  localparam logic [7:0] TYPE_HIGH     = 8'd8;
  localparam logic [7:0] OVL_LOW       = 8'd1;
  localparam logic [7:0] OVL_HIGH      = 8'd3;

  typedef enum logic [6:0] {
    PH_COOKIE  = 7'b0000001,
    PH_CODE    = 7'b0000010,
    PH_LEN     = 7'b0000100,
    PH_VALUE   = 7'b0001000,
    PH_SKIPLEN = 7'b0010000,
    PH_SKIPVAL = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       seen;
    logic [7:0] len;
    logic [7:0] val;
  } opt_rec_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'd99;
      2'd1:    m = 8'd130;
      2'd2:    m = 8'd83;
      default: m = 8'd99;
    endcase
    return m;
  endfunction

  phase_t           phase_r, phase_nxt, ph_eff;
  logic [1:0]       cidx_r, cidx_nxt;
  logic             magic_r, magic_nxt;
  logic [7:0]       pcode_r, pcode_nxt;
  logic [7:0]       plen_r, plen_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic             prec_r, prec_nxt;
  logic [9:0]       poff_r, poff_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [POS_W+9:0] pos_wide;
  logic [255:0]     seen_r, seen_nxt;
  opt_rec_t         type_r, type_nxt;
  opt_rec_t         ovl_r, ovl_nxt;
  logic             emit;
  logic             reg0;
  logic [7:0]       b;
  logic [2:0]       st;
  logic [1:0]       ov;
  out_beat_t        rec_beat, sum_beat;

  assign b        = beat.data_byte;
  assign reg0     = (beat.region == 2'd0);
  assign pos_wide = {10'd0, pos_eff};

  always_comb begin
    phase_nxt = phase_r;
    cidx_nxt  = cidx_r;
    magic_nxt = magic_r;
    pcode_nxt = pcode_r;
    plen_nxt  = plen_r;
    rem_nxt   = rem_r;
    prec_nxt  = prec_r;
    poff_nxt  = poff_r;
    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    type_nxt  = type_r;
    ovl_nxt   = ovl_r;
    emit      = 1'b0;

    if (beat.first_byte) begin
      if (reg0) begin
        magic_nxt = 1'b0;
        seen_nxt  = '0;
        type_nxt  = '0;
        ovl_nxt   = '0;
        phase_nxt = PH_COOKIE;
        cidx_nxt  = 2'd0;
      end else begin
        phase_nxt = magic_r ? PH_CODE : PH_DONE;
      end
      prec_nxt = 1'b0;
      pos_nxt  = '0;
    end

    pos_eff = pos_nxt;
    ph_eff  = phase_nxt;

    if (pos_eff < POS_MAX) begin
      pos_nxt = pos_eff + POS_W'(1);
      case (ph_eff)
        PH_COOKIE: begin
          if (b != magic_byte(cidx_nxt)) begin
            phase_nxt = PH_DONE;
          end else if (cidx_nxt == 2'd3) begin
            magic_nxt = 1'b1;
            phase_nxt = PH_CODE;
          end else begin
            cidx_nxt = cidx_nxt + 2'd1;
          end
        end
        PH_CODE: begin
          if (b == CODE_PAD) begin
            phase_nxt = PH_CODE;
          end else if (b == CODE_END) begin
            phase_nxt = PH_DONE;
          end else if (b > max_code) begin
            phase_nxt = PH_SKIPLEN;
          end else begin
            pcode_nxt = b;
            poff_nxt  = pos_wide[9:0];
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          plen_nxt = b;
          prec_nxt = !seen_r[pcode_r];
          if (b == 8'd0) begin
            emit      = prec_nxt;
            phase_nxt = PH_CODE;
          end else begin
            rem_nxt   = b;
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (rem_r == plen_r && prec_r && reg0) begin
            if (pcode_r == CODE_TYPE) begin
              type_nxt.val = b;
            end else if (pcode_r == CODE_OVERLOAD) begin
              ovl_nxt.val = b;
            end
          end
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == 8'd0) begin
            emit      = prec_r;
            phase_nxt = PH_CODE;
          end
        end
        PH_SKIPLEN: begin
          rem_nxt   = b;
          phase_nxt = (b == 8'd0) ? PH_CODE : PH_SKIPVAL;
        end
        PH_SKIPVAL: begin
          rem_nxt = rem_r - 8'd1;
          if (rem_nxt == 8'd0) begin
            phase_nxt = PH_CODE;
          end
        end
        default: begin
          phase_nxt = ph_eff;
        end
      endcase
    end

    // accept the pending option
    if (emit) begin
      seen_nxt[pcode_nxt] = 1'b1;
      if (reg0) begin
        if (pcode_nxt == CODE_TYPE) begin
          type_nxt.seen = 1'b1;
          type_nxt.len  = plen_nxt;
        end else if (pcode_nxt == CODE_OVERLOAD) begin
          ovl_nxt.seen = 1'b1;
          ovl_nxt.len  = plen_nxt;
        end
      end
      prec_nxt = 1'b0;
    end

    if (beat.last_byte) begin
      phase_nxt = PH_DONE;
      prec_nxt  = 1'b0;
    end
  end

  // region summary from the updated packet state
  always_comb begin
    st = ST_OK;
    ov = 2'd0;
    if (!magic_nxt) begin
      st = ST_NO_MAGIC;
    end else if (type_nxt.seen) begin
      if (type_nxt.len != 8'd1) begin
        st = ST_GARBLED_TYPE;
      end else if (!(type_nxt.val inside {[TYPE_LOW:TYPE_HIGH]})) begin
        st = ST_WRONG_TYPE;
      end else if (ovl_nxt.seen) begin
        if (ovl_nxt.len != 8'd1 || !(ovl_nxt.val inside {[OVL_LOW:OVL_HIGH]})) begin
          st = ST_BAD_OVERLOAD;
        end else begin
          ov = ovl_nxt.val[1:0];
        end
      end
    end
  end

  always_comb begin
    rec_beat                = '0;
    rec_beat.result_kind    = KIND_OPTION;
    rec_beat.option_code    = pcode_nxt;
    rec_beat.option_offset  = poff_nxt;
    rec_beat.option_length  = plen_nxt;
    rec_beat.last_of_run    = !beat.last_byte;
    sum_beat                = '0;
    sum_beat.result_kind    = KIND_SUMMARY;
    sum_beat.status         = st;
    sum_beat.overload_value = ov;
    sum_beat.last_of_run    = 1'b1;
    res.r1 = sum_beat;
    if (emit) begin
      res.r0  = rec_beat;
      res.cnt = beat.last_byte ? 2'd2 : 2'd1;
    end else begin
      res.r0  = sum_beat;
      res.cnt = beat.last_byte ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COOKIE;
      cidx_r  <= 2'd0;
      magic_r <= 1'b0;
      pcode_r <= 8'd0;
      plen_r  <= 8'd0;
      rem_r   <= 8'd0;
      prec_r  <= 1'b0;
      poff_r  <= 10'd0;
      pos_r   <= '0;
      seen_r  <= '0;
      type_r  <= '0;
      ovl_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cidx_r  <= cidx_nxt;
      magic_r <= magic_nxt;
      pcode_r <= pcode_nxt;
      plen_r  <= plen_nxt;
      rem_r   <= rem_nxt;
      prec_r  <= prec_nxt;
      poff_r  <= poff_nxt;
      pos_r   <= pos_nxt;
      seen_r  <= seen_nxt;
      type_r  <= type_nxt;
      ovl_r   <= ovl_nxt;
    end
  end

endmodule

>>> src/dhcpos_outq.sv
// four-entry result queue taking up to two results per cycle
module dhcpos_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dhcpos_pkg::res_pair_t res,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dhcpos_pkg::out_beat_t out_data
);
  import dhcpos_pkg::*;

  out_beat_t  mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign room      = (cnt_r <= 3'd2);
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign n_push    = push ? res.cnt : 2'd0;

  always_comb begin
    wr_nxt  = wr_r + n_push;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, n_push} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_r] <= res.r0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_r + 2'd1] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/dhcp_option_scanner_top.sv
// top level of the dhcp option scanner
// in_*: one packet byte per beat with region tag and first/last marks.
//   a first mark in region 0 starts a new packet; regions 1 and 2 (file, sname)
//   are walked only after a good magic cookie.
// out_*: option records (code, offset, length) and, on each last byte, a
//   region summary with status and overload value; last_of_run marks the final
//   result of one input byte.
// cfg_*: writes highest_known_code, taken every cycle; write only while idle.
// path: an accepted byte waits in the input register until the queue has room,
//   is parsed, and its results are written into the queue that drives out_valid.
// throughput: one byte per cycle while the queue has room for two results;
//   the parse state advances once per accepted byte.
// a byte that yields two results takes two output beats from the four-entry
//   result queue.
// stall: when out_ready is low the queue fills; once fewer than two slots are
//   free the input register holds and in_ready drops, nothing is lost.
// reset: parser waits for a region 0 cookie, highest_known_code is 254,
//   the queue is empty.
module dhcp_option_scanner_top #(
  parameter int MAX_REGION_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dhcpos_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dhcpos_pkg::out_beat_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import dhcpos_pkg::*;

  in_beat_t  in_r;
  logic      hold_r;
  logic [7:0] hkc_r;
  logic      room;
  logic      step;
  res_pair_t res;

  assign step      = hold_r && room;
  assign in_ready  = !hold_r || room;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      hkc_r  <= HKC_RESET;
    end else begin
      if (in_valid && in_ready) begin
        hold_r <= 1'b1;
      end else if (step) begin
        hold_r <= 1'b0;
      end
      if (cfg_valid) begin
        hkc_r <= cfg_data;
      end
    end
  end

  dhcpos_parse #(
    .MAX_REGION_BYTES(MAX_REGION_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .beat     (in_r),
    .max_code (hkc_r),
    .res      (res)
  );

  dhcpos_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/dhcpos_check.sv
// scoreboard for the dhcp option scanner: predicts the result beats of each byte and checks them
module dhcpos_check #(
  parameter int MAX_REGION_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  dhcpos_pkg::in_beat_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  dhcpos_pkg::out_beat_t out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [7:0]            cfg_data,
  output int                    err_count,
  output int                    n_expected
);
  import dhcpos_pkg::*;

  typedef enum logic [2:0] {
    SCAN_COOKIE,
    SCAN_CODE,
    SCAN_LEN,
    SCAN_VALUE,
    SCAN_SKIP_LEN,
    SCAN_SKIP_VALUE,
    SCAN_DONE
  } scan_phase_t;

  localparam logic [31:0] MAGIC_COOKIE = {8'd99, 8'd130, 8'd83, 8'd99};
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_OVERLOAD = 8'd52;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] MSG_TYPE_MIN = 8'd1;
  localparam logic [7:0] MSG_TYPE_MAX = 8'd8;
  localparam logic [7:0] OVERLOAD_MIN = 8'd1;
  localparam logic [7:0] OVERLOAD_MAX = 8'd3;

  logic [7:0]   known_limit;
  scan_phase_t  phase;
  logic [1:0]   cookie_idx;
  logic         magic_ok;
  logic [7:0]   opt_code;
  logic [7:0]   opt_len;
  logic [7:0]   left;
  logic         opt_new;
  logic [9:0]   opt_offset;
  int unsigned  pos;
  logic [255:0] codes_seen;
  logic         type_seen;
  logic [7:0]   type_len;
  logic [7:0]   type_val;
  logic         ovl_seen;
  logic [7:0]   ovl_len;
  logic [7:0]   ovl_val;
  out_beat_t    pending_results[$];
  out_beat_t    want;

  // marks the open option as taken; true when it yields a record
  function automatic logic close_option(input logic [1:0] rgn);
    if (!opt_new) return 1'b0;
    codes_seen[opt_code] = 1'b1;
    if (rgn == 2'd0) begin
      if (opt_code == OPT_MSG_TYPE) begin
        type_seen = 1'b1;
        type_len  = opt_len;
      end else if (opt_code == OPT_OVERLOAD) begin
        ovl_seen = 1'b1;
        ovl_len  = opt_len;
      end
    end
    opt_new = 1'b0;
    return 1'b1;
  endfunction

  task automatic scan_byte(input in_beat_t b);
    int unsigned at;
    logic        emit;
    out_beat_t   r;
    emit = 1'b0;
    if (b.first_byte) begin
      if (b.region == 2'd0) begin
        magic_ok   = 1'b0;
        codes_seen = '0;
        type_seen  = 1'b0;
        type_len   = '0;
        type_val   = '0;
        ovl_seen   = 1'b0;
        ovl_len    = '0;
        ovl_val    = '0;
        phase      = SCAN_COOKIE;
        cookie_idx = '0;
      end else begin
        phase = magic_ok ? SCAN_CODE : SCAN_DONE;
      end
      opt_new = 1'b0;
      pos     = 0;
    end
    at = pos;
    if (at < MAX_REGION_BYTES) begin
      pos = at + 1;
      case (phase)
        SCAN_COOKIE: begin
          if (b.data_byte != MAGIC_COOKIE[8*(3-cookie_idx) +: 8]) begin
            phase = SCAN_DONE;
          end else if (cookie_idx == 2'd3) begin
            magic_ok = 1'b1;
            phase    = SCAN_CODE;
          end else begin
            cookie_idx++;
          end
        end
        SCAN_CODE: begin
          if (b.data_byte == OPT_END) begin
            phase = SCAN_DONE;
          end else if (b.data_byte != OPT_PAD) begin
            if (b.data_byte > known_limit) begin
              phase = SCAN_SKIP_LEN;
            end else begin
              opt_code   = b.data_byte;
              opt_offset = at[9:0];
              phase      = SCAN_LEN;
            end
          end
        end
        SCAN_LEN: begin
          opt_len = b.data_byte;
          opt_new = !codes_seen[opt_code];
          if (b.data_byte == 8'd0) begin
            emit  = close_option(b.region);
            phase = SCAN_CODE;
          end else begin
            left  = b.data_byte;
            phase = SCAN_VALUE;
          end
        end
        SCAN_VALUE: begin
          if (left == opt_len && opt_new && b.region == 2'd0) begin
            if (opt_code == OPT_MSG_TYPE) type_val = b.data_byte;
            else if (opt_code == OPT_OVERLOAD) ovl_val = b.data_byte;
          end
          left = left - 8'd1;
          if (left == 8'd0) begin
            emit  = close_option(b.region);
            phase = SCAN_CODE;
          end
        end
        SCAN_SKIP_LEN: begin
          left  = b.data_byte;
          phase = (b.data_byte == 8'd0) ? SCAN_CODE : SCAN_SKIP_VALUE;
        end
        SCAN_SKIP_VALUE: begin
          left = left - 8'd1;
          if (left == 8'd0) phase = SCAN_CODE;
        end
        default: begin
        end
      endcase
    end
    if (emit) begin
      r               = '0;
      r.result_kind   = KIND_OPTION;
      r.option_code   = opt_code;
      r.option_offset = opt_offset;
      r.option_length = opt_len;
      r.last_of_run   = !b.last_byte;
      pending_results.push_back(r);
    end
    if (b.last_byte) begin
      r             = '0;
      r.result_kind = KIND_SUMMARY;
      r.status      = ST_OK;
      r.last_of_run = 1'b1;
      if (!magic_ok) begin
        r.status = ST_NO_MAGIC;
      end else if (type_seen) begin
        if (type_len != 8'd1) begin
          r.status = ST_GARBLED_TYPE;
        end else if (type_val < MSG_TYPE_MIN || type_val > MSG_TYPE_MAX) begin
          r.status = ST_WRONG_TYPE;
        end else if (ovl_seen) begin
          if (ovl_len != 8'd1 || ovl_val < OVERLOAD_MIN || ovl_val > OVERLOAD_MAX) begin
            r.status = ST_BAD_OVERLOAD;
          end else begin
            r.overload_value = ovl_val[1:0];
          end
        end
      end
      pending_results.push_back(r);
      phase   = SCAN_DONE;
      opt_new = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [9:0] want_v,
                             input logic [9:0] got_v);
    if (got_v !== want_v) begin
      err_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      known_limit = HKC_RESET;
      phase       = SCAN_COOKIE;
      cookie_idx  = '0;
      magic_ok    = 1'b0;
      opt_code    = '0;
      opt_len     = '0;
      left        = '0;
      opt_new     = 1'b0;
      opt_offset  = '0;
      pos         = 0;
      codes_seen  = '0;
      type_seen   = 1'b0;
      type_len    = '0;
      type_val    = '0;
      ovl_seen    = 1'b0;
      ovl_len     = '0;
      ovl_val     = '0;
      pending_results.delete();
      err_count   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: result beat expected none got %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 10'(want.result_kind), 10'(out_data.result_kind));
          check_field("option_code", 10'(want.option_code), 10'(out_data.option_code));
          check_field("option_offset", want.option_offset, out_data.option_offset);
          check_field("option_length", 10'(want.option_length),
                      10'(out_data.option_length));
          check_field("status", 10'(want.status), 10'(out_data.status));
          check_field("overload_value", 10'(want.overload_value),
                      10'(out_data.overload_value));
          check_field("last_of_run", 10'(want.last_of_run), 10'(out_data.last_of_run));
        end
      end
      if (in_valid && in_ready) scan_byte(in_data);
      if (cfg_valid && cfg_ready) known_limit = cfg_data;
    end
    n_expected = pending_results.size();
  end

endmodule

>>> test/tb.sv
// testbench top for the dhcp option scanner: drives packet regions and limit writes, gives the verdict
module tb;
  import dhcpos_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int PHASE_ITEMS   = 120;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [31:0] MAGIC_COOKIE = {8'd99, 8'd130, 8'd83, 8'd99};
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_OVERLOAD = 8'd52;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_beat_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  int         err_count;
  int         n_expected;
  int         n_sent = 0;
  int         cycle_count = 0;
  int         out_hold = 0;
  int         out_pick;
  bit         in_idle_on = 1'b1;
  bit         out_stall_on = 1'b1;
  logic [7:0] limit_now = HKC_RESET;
  logic [7:0] pkt_bytes[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dhcp_option_scanner_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  dhcpos_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .err_count  (err_count),
    .n_expected (n_expected)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver pacing: mostly short stalls, a few long ones, stretches with none
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 2) out_stall_on = !out_stall_on;
      if (out_stall_on) begin
        out_pick = $urandom_range(0, 99);
        if (out_pick >= 95) out_hold = $urandom_range(5, 40);
        else if (out_pick >= 60) out_hold = $urandom_range(1, 3);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic [1:0] rgn,
                           input logic f, input logic l);
    int gap;
    int pick;
    gap = 0;
    if ($urandom_range(0, 99) < 2) in_idle_on = !in_idle_on;
    if (in_idle_on) begin
      pick = $urandom_range(0, 99);
      if (pick >= 95) gap = $urandom_range(4, 30);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {d, rgn, f, l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_region(input logic [1:0] rgn);
    int last_idx;
    last_idx = pkt_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) send_byte(pkt_bytes[i], rgn, i == 0, i == last_idx);
    pkt_bytes.delete();
  endtask

  task automatic add_cookie(input int n);
    for (int k = 0; k < n; k++) pkt_bytes.push_back(MAGIC_COOKIE[8*(3-k) +: 8]);
  endtask

  task automatic add_option(input logic [7:0] code, input logic [7:0] len,
                            input logic [7:0] v0);
    logic [7:0] fill;
    pkt_bytes.push_back(code);
    pkt_bytes.push_back(len);
    for (int i = 0; i < len; i++) begin
      fill = 8'($urandom_range(0, 255));
      pkt_bytes.push_back(i == 0 ? v0 : fill);
    end
  endtask

  task automatic add_random_option();
    int         pick;
    logic [7:0] code;
    logic [7:0] len;
    logic [7:0] v0;
    pick = $urandom_range(0, 99);
    v0   = 8'($urandom_range(0, 255));
    if (pick < 8) begin
      pkt_bytes.push_back(OPT_PAD);
    end else if (pick < 12) begin
      pkt_bytes.push_back(OPT_END);
    end else begin
      if (pick < 26) begin
        code = OPT_MSG_TYPE;
        v0   = 8'(($urandom_range(0, 99) < 75) ? $urandom_range(1, 8) : $urandom_range(0, 12));
      end else if (pick < 36) begin
        code = OPT_OVERLOAD;
        v0   = 8'(($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(0, 6));
      end else if (pick < 66) begin
        case ($urandom_range(0, 5))
          0: code = 8'd1;
          1: code = 8'd3;
          2: code = 8'd6;
          3: code = 8'd12;
          4: code = 8'd51;
          default: code = 8'd61;
        endcase
      end else if (pick < 76) begin
        code = 8'(limit_now + $urandom_range(0, 2) - 1);
      end else begin
        code = 8'($urandom_range(1, 254));
      end
      if (code == OPT_MSG_TYPE || code == OPT_OVERLOAD) begin
        len = ($urandom_range(0, 99) < 80) ? 8'd1 : 8'($urandom_range(0, 3));
      end else begin
        pick = $urandom_range(0, 999);
        if (pick < 850) len = 8'($urandom_range(0, 6));
        else if (pick < 993) len = 8'($urandom_range(7, 20));
        else len = 8'($urandom_range(128, 255));
      end
      add_option(code, len, v0);
    end
  endtask

  task automatic add_options(input int count);
    for (int i = 0; i < count; i++) add_random_option();
    if ($urandom_range(0, 99) < 20) begin
      pkt_bytes.push_back(OPT_END);
      repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_extra_region(input logic [1:0] rgn);
    add_options($urandom_range(0, 4));
    if (pkt_bytes.size() == 0) pkt_bytes.push_back(OPT_END);
    send_region(rgn);
  endtask

  task automatic run_packet();
    int         pick;
    int         k;
    logic [7:0] junk;
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      add_cookie(4);
    end else if (pick < 94) begin
      add_cookie(4);
      k = $urandom_range(0, 3);
      pkt_bytes[k] = pkt_bytes[k] ^ 8'($urandom_range(1, 255));
    end else begin
      add_cookie($urandom_range(0, 3));
    end
    add_options($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) if (pkt_bytes.size() > 1) junk = pkt_bytes.pop_back();
    end
    if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    send_region(2'd0);
    if ($urandom_range(0, 99) < 50) send_extra_region(2'd1);
    if ($urandom_range(0, 99) < 40) send_extra_region(2'd2);
    if ($urandom_range(0, 99) < 4) send_extra_region(2'd3);
    // stray beats with arbitrary tags and marks
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 4)) begin
        send_byte(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_expected != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  task automatic run_items(input int count);
    int target;
    target = n_sent + count;
    while (n_sent < target) begin
      run_packet();
      if ($urandom_range(0, 99) < 3) drain();
    end
  endtask

  // region 0 past the size limit with an option open across the boundary
  task automatic send_oversized();
    add_cookie(4);
    add_option(OPT_MSG_TYPE, 8'd1, 8'd3);
    while (pkt_bytes.size() < 1000) begin
      add_option(8'($urandom_range(1, 254)), 8'($urandom_range(0, 20)),
                 8'($urandom_range(0, 255)));
    end
    add_option(8'd7, 8'd40, 8'($urandom_range(0, 255)));
    repeat (4) pkt_bytes.push_back(8'($urandom_range(0, 255)));
    send_region(2'd0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unmarked bytes after reset count as a region 0 cookie
    add_cookie(4);
    add_option(OPT_MSG_TYPE, 8'd1, 8'd5);
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      send_byte(pkt_bytes[i], 2'd0, 1'b0, i == pkt_bytes.size() - 1);
    end
    pkt_bytes.delete();
    // ignored after a region end
    send_byte(8'h5a, 2'd0, 1'b0, 1'b0);
    // file field: zero length option, pad, end
    send_byte(8'd12, 2'd1, 1'b1, 1'b0);
    send_byte(8'd0, 2'd1, 1'b0, 1'b0);
    send_byte(OPT_PAD, 2'd1, 1'b0, 1'b0);
    send_byte(OPT_END, 2'd1, 1'b0, 1'b0);
    send_byte(8'hff, 2'd1, 1'b0, 1'b1);
    // cookie cut short
    send_byte(MAGIC_COOKIE[31:24], 2'd0, 1'b1, 1'b0);
    send_byte(MAGIC_COOKIE[23:16], 2'd0, 1'b0, 1'b1);
    // regions after a bad cookie are skipped
    send_byte(8'd1, 2'd2, 1'b1, 1'b1);
    send_byte(8'd1, 2'd3, 1'b1, 1'b1);
    // highest code taken, then an option cut by the region end
    add_cookie(4);
    add_option(8'd254, 8'd1, 8'haa);
    pkt_bytes.push_back(8'd1);
    pkt_bytes.push_back(8'd5);
    send_region(2'd0);

    write_limit(8'd1);
    run_items(PHASE_ITEMS);
    write_limit(8'd53);
    run_items(PHASE_ITEMS);
    write_limit(8'd52);
    run_items(PHASE_ITEMS);
    write_limit(8'd254);
    send_oversized();
    run_items(PHASE_ITEMS);
    write_limit(8'd128);
    run_items(PHASE_ITEMS);
    write_limit(8'($urandom_range(2, 253)));
    run_items(PHASE_ITEMS);
    drain();

    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/dhcpos_pkg.sv
src/dhcpos_parse.sv
src/dhcpos_outq.sv
src/dhcp_option_scanner_top.sv
test/dhcpos_check.sv
test/tb.sv
